// ----- rtl/bbri_pkg.sv -----
// Shared constants for the blackbody band intensity pipeline: field widths,
// stage counts, wavelength constants and the exponential bit table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbri_pkg;

    localparam int TEMP_W = 16;
    localparam int OUT_W = 40;
    localparam int KZ_W = 40;
    localparam int Z_W = 29;
    localparam int REM_W = TEMP_W + Z_W;
    localparam int Z2_W = 34;
    localparam int Z3_W = 39;
    localparam int P_W = 40;
    localparam int HALF_P = P_W / 2;
    localparam int E_W = 33;
    localparam int PP_W = HALF_P + E_W;
    localparam int SUM_W = 30;
    localparam int F_W = 25;
    localparam int PWR_W = 56;
    localparam int HALF_PWR = PWR_W / 2;
    localparam int BP_W = HALF_PWR + F_W;

    localparam int DIV_STAGES = Z_W;
    localparam int EXP_STAGES = 29;
    localparam int LANE_LAT = 1 + DIV_STAGES + 3 + EXP_STAGES + 4;
    localparam int POW_LAT = 4;
    localparam int DLY_LEN = LANE_LAT - POW_LAT;
    localparam int TOT_LAT = LANE_LAT + 3;

    localparam int NUM_EDGES = 4;
    localparam int NUM_COLORS = 3;
    localparam int COL_RED = 0;
    localparam int COL_GREEN = 1;
    localparam int COL_BLUE = 2;

    localparam logic [63:0] C2_Q24 = 64'd1438776877 << 24;
    localparam logic [KZ_W-1:0] KZ_700 = KZ_W'(C2_Q24 / 64'd70000);
    localparam logic [KZ_W-1:0] KZ_600 = KZ_W'(C2_Q24 / 64'd60000);
    localparam logic [KZ_W-1:0] KZ_500 = KZ_W'(C2_Q24 / 64'd50000);
    localparam logic [KZ_W-1:0] KZ_400 = KZ_W'(C2_Q24 / 64'd40000);
    localparam logic [KZ_W-1:0] KZ_TAB [NUM_EDGES] = '{KZ_700, KZ_600, KZ_500, KZ_400};

    localparam logic [31:0] SIGMA_Q56 = 32'd4085935379;
    localparam logic [SUM_W-1:0] FRAC_SCALE_Q32 = SUM_W'(661380871);
    localparam logic [P_W-1:0] SIX_Q24 = P_W'(6) << 24;
    localparam logic [F_W-1:0] ONE_Q24 = F_W'(1) << 24;
    localparam logic [63:0] ROUND_24 = 64'd1 << 23;
    localparam logic [63:0] ROUND_32 = 64'd1 << 31;
    localparam logic [E_W-1:0] EXP_ONE = E_W'(1) << 32;

    localparam logic [31:0] EXP_TAB [EXP_STAGES] = '{
        32'd4294967040, 32'd4294966784, 32'd4294966272, 32'd4294965248, 32'd4294963200,
        32'd4294959104, 32'd4294950912, 32'd4294934528, 32'd4294901760, 32'd4294836226,
        32'd4294705160, 32'd4294443040, 32'd4293918848, 32'd4292870656, 32'd4290775039,
        32'd4286586875, 32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347, 32'd1580030169,
        32'd581260615, 32'd78665070, 32'd1440801, 32'd483
    };

endpackage

`default_nettype wire

// ----- rtl/bbri_stream_if.sv -----
// Valid/ready channel interfaces for the temperature request and the
// color intensity result. Depends on bbri_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bbri_temp_if;
    import bbri_pkg::*;

    logic valid;
    logic ready;
    logic [TEMP_W-1:0] temperature_k;

    modport source (output valid, output temperature_k, input ready);
    modport sink (input valid, input temperature_k, output ready);
endinterface

interface bbri_rgb_if;
    import bbri_pkg::*;

    logic valid;
    logic ready;
    logic [OUT_W-1:0] red_intensity;
    logic [OUT_W-1:0] green_intensity;
    logic [OUT_W-1:0] blue_intensity;

    modport source (output valid, output red_intensity, output green_intensity,
                    output blue_intensity, input ready);
    modport sink (input valid, input red_intensity, input green_intensity,
                  input blue_intensity, output ready);
endinterface

`default_nettype wire

// ----- rtl/bbri_lane.sv -----
// Cumulative blackbody fraction below one wavelength edge: restoring divider,
// cubic polynomial, bitwise exponential chain and final scaling.
// Depends on bbri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbri_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [bbri_pkg::TEMP_W-1:0] t,
    input  logic [bbri_pkg::KZ_W-1:0]   kz,
    output logic [bbri_pkg::F_W-1:0]    f
);
    import bbri_pkg::*;

    logic [REM_W-1:0]      rem_reg [DIV_STAGES];
    logic [TEMP_W-1:0]     div_t_reg [DIV_STAGES];
    logic [Z_W-1:0]        quo_reg [DIV_STAGES+1];
    logic [DIV_STAGES:0]   div_sat_reg;

    logic [Z_W-1:0]        sq_z_reg;
    logic [Z2_W-1:0]       sq_z2_reg;
    logic                  sq_sat_reg;
    logic [Z_W-1:0]        cu_z_reg;
    logic [Z2_W-1:0]       cu_z2_reg;
    logic [Z3_W-1:0]       cu_z3_reg;
    logic                  cu_sat_reg;

    logic [E_W-1:0]        ex_acc1_reg [EXP_STAGES+1];
    logic [E_W-1:0]        ex_acc2_reg [EXP_STAGES+1];
    logic [Z_W-1:0]        ex_z_reg [EXP_STAGES+1];
    logic [P_W-1:0]        ex_p1_reg [EXP_STAGES+1];
    logic [P_W-1:0]        ex_p2_reg [EXP_STAGES+1];
    logic [EXP_STAGES:0]   ex_sat_reg;

    logic [PP_W-1:0]       pl1_reg, ph1_reg, pl2_reg, ph2_reg;
    logic                  mp_sat_reg;
    logic [SUM_W-1:0]      tm1_reg, tm2_reg;
    logic                  tm_sat_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  sum_sat_reg;
    logic [F_W-1:0]        f_reg;

    logic [2*Z_W-1:0]      zsq_rnd;
    logic [Z2_W+Z_W-1:0]   zcu_rnd;
    logic [Z2_W+1:0]       z2x3;
    logic [Z_W+2:0]        zx6;
    logic [P_W-1:0]        p1_next, p2_next;
    logic [E_W-1:0]        e1, e2;
    logic [PP_W+HALF_P-1:0] full1, full2;
    logic [2*SUM_W-1:0]    fprod;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(kz);
            div_t_reg[0] <= t;
            quo_reg[0] <= '0;
            div_sat_reg[0] <= REM_W'(kz) >= {t, Z_W'(0)};
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_div
        localparam int B = DIV_STAGES - s;
        localparam logic [Z_W-1:0] QBIT = Z_W'(1) << B;
        logic [REM_W-1:0] dsr;
        logic take;

        assign dsr = REM_W'(div_t_reg[s-1]) << B;
        assign take = rem_reg[s-1] >= dsr;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= take ? (quo_reg[s-1] | QBIT) : quo_reg[s-1];
                div_sat_reg[s] <= div_sat_reg[s-1];
            end
        end

        if (s < DIV_STAGES)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? rem_reg[s-1] - dsr : rem_reg[s-1];
                    div_t_reg[s] <= div_t_reg[s-1];
                end
            end
        end
    end

    assign zsq_rnd = quo_reg[DIV_STAGES] * quo_reg[DIV_STAGES] + (2*Z_W)'(ROUND_24);
    assign zcu_rnd = sq_z2_reg * sq_z_reg + (Z2_W+Z_W)'(ROUND_24);
    assign z2x3 = (Z2_W+2)'({cu_z2_reg, 1'b0}) + (Z2_W+2)'(cu_z2_reg);
    assign zx6 = (Z_W+3)'({cu_z_reg, 2'b0}) + (Z_W+3)'({cu_z_reg, 1'b0});
    assign p1_next = P_W'(cu_z3_reg) + P_W'(z2x3) + P_W'(zx6) + SIX_Q24;
    assign p2_next = P_W'(cu_z3_reg) + P_W'(z2x3 >> 1) + P_W'(zx6 >> 2) + (SIX_Q24 >> 3);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_z_reg <= quo_reg[DIV_STAGES];
            sq_z2_reg <= zsq_rnd[2*Z_W-1:24];
            sq_sat_reg <= div_sat_reg[DIV_STAGES];

            cu_z_reg <= sq_z_reg;
            cu_z2_reg <= sq_z2_reg;
            cu_z3_reg <= zcu_rnd[Z2_W+Z_W-1:24];
            cu_sat_reg <= sq_sat_reg;

            ex_acc1_reg[0] <= EXP_ONE;
            ex_acc2_reg[0] <= EXP_ONE;
            ex_z_reg[0] <= cu_z_reg;
            ex_p1_reg[0] <= p1_next;
            ex_p2_reg[0] <= p2_next;
            ex_sat_reg[0] <= cu_sat_reg;
        end
    end

    for (genvar k = 1; k <= EXP_STAGES; k++)
    begin : g_exp
        localparam int B = k - 1;
        logic [E_W+31:0] m1, m2;
        logic take2;

        assign m1 = ex_acc1_reg[k-1] * EXP_TAB[B] + (E_W+32)'(ROUND_32);
        assign m2 = ex_acc2_reg[k-1] * EXP_TAB[B] + (E_W+32)'(ROUND_32);

        if (B == 0)
        begin : g_lsb
            assign take2 = 1'b0;
        end
        else
        begin : g_bit
            assign take2 = ex_z_reg[k-1][B-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ex_acc1_reg[k] <= ex_z_reg[k-1][B] ? m1[E_W+31:32] : ex_acc1_reg[k-1];
                ex_acc2_reg[k] <= take2 ? m2[E_W+31:32] : ex_acc2_reg[k-1];
                ex_z_reg[k] <= ex_z_reg[k-1];
                ex_p1_reg[k] <= ex_p1_reg[k-1];
                ex_p2_reg[k] <= ex_p2_reg[k-1];
                ex_sat_reg[k] <= ex_sat_reg[k-1];
            end
        end
    end

    // The doubled argument reaches the saturation limit when the top bit of z is set.
    assign e1 = ex_acc1_reg[EXP_STAGES];
    assign e2 = ex_z_reg[EXP_STAGES][Z_W-1] ? '0 : ex_acc2_reg[EXP_STAGES];

    assign full1 = {ph1_reg, HALF_P'(0)} + (PP_W+HALF_P)'(pl1_reg);
    assign full2 = {ph2_reg, HALF_P'(0)} + (PP_W+HALF_P)'(pl2_reg);
    assign fprod = sum_reg * FRAC_SCALE_Q32 + (2*SUM_W)'(ROUND_32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl1_reg <= ex_p1_reg[EXP_STAGES][HALF_P-1:0] * e1;
            ph1_reg <= ex_p1_reg[EXP_STAGES][P_W-1:HALF_P] * e1;
            pl2_reg <= ex_p2_reg[EXP_STAGES][HALF_P-1:0] * e2;
            ph2_reg <= ex_p2_reg[EXP_STAGES][P_W-1:HALF_P] * e2;
            mp_sat_reg <= ex_sat_reg[EXP_STAGES];

            tm1_reg <= full1[SUM_W+31:32];
            tm2_reg <= full2[SUM_W+32:33];
            tm_sat_reg <= mp_sat_reg;

            sum_reg <= tm1_reg + tm2_reg;
            sum_sat_reg <= tm_sat_reg;

            f_reg <= sum_sat_reg ? '0 : fprod[F_W+31:32];
        end
    end

    assign f = f_reg;

endmodule

`default_nettype wire

// ----- rtl/blackbody_rgb_intensity.sv -----
// Top level: red, green and blue blackbody band intensities from a temperature.
// Depends on bbri_pkg, bbri_stream_if and bbri_lane.
//
//   Channel  Direction  Payload
//   temp     request    temperature_k (16 bits)
//   rgb      result     red_intensity, green_intensity, blue_intensity (40 bits each)
//
// One request is taken every cycle while the rgb result is not stalled.
// Most of the pipeline depth is the 29-step divider and the 29-step exponential chain.
// Reset clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module blackbody_rgb_intensity (
    input  logic clk,
    input  logic rst_n,
    bbri_temp_if.sink temp,
    bbri_rgb_if.source rgb
);
    import bbri_pkg::*;

    logic                en;
    logic [TOT_LAT:1]    vld_reg;
    logic [F_W-1:0]      f_edge [NUM_EDGES];
    logic [TEMP_W-1:0]   dly_t_reg [DLY_LEN];
    logic [2*TEMP_W-1:0] t2_reg;
    logic [4*TEMP_W-1:0] t4_reg;
    logic [63:0]         pwlo_reg, pwhi_reg;
    logic [95:0]         pw_full;
    logic [PWR_W-1:0]    pwr_reg, bpwr_reg;
    logic [F_W-1:0]      band_reg [NUM_COLORS];
    logic [BP_W-1:0]     mlo_reg [NUM_COLORS];
    logic [BP_W-1:0]     mhi_reg [NUM_COLORS];
    logic [OUT_W-1:0]    out_reg [NUM_COLORS];

    assign en = !vld_reg[TOT_LAT] || rgb.ready;
    assign temp.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOT_LAT-1:1], temp.valid};
        end
    end

    for (genvar i = 0; i < NUM_EDGES; i++)
    begin : g_lane
        bbri_lane u_lane (
            .clk (clk),
            .en  (en),
            .t   (temp.temperature_k),
            .kz  (KZ_TAB[i]),
            .f   (f_edge[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_t_reg[0] <= temp.temperature_k;
            for (int i = 1; i < DLY_LEN; i++)
            begin
                dly_t_reg[i] <= dly_t_reg[i-1];
            end
        end
    end

    assign pw_full = {pwhi_reg, 32'd0} + 96'(pwlo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg <= dly_t_reg[DLY_LEN-1] * dly_t_reg[DLY_LEN-1];
            t4_reg <= t2_reg * t2_reg;
            pwlo_reg <= t4_reg[31:0] * SIGMA_Q56;
            pwhi_reg <= t4_reg[63:32] * SIGMA_Q56;
            pwr_reg <= pw_full[PWR_W+39:40];
            bpwr_reg <= pwr_reg;
        end
    end

    for (genvar c = 0; c < NUM_COLORS; c++)
    begin : g_color
        logic [BP_W+HALF_PWR-1:0] full;

        assign full = {mhi_reg[c], HALF_PWR'(0)} + (BP_W+HALF_PWR)'(mlo_reg[c]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                band_reg[c] <= (f_edge[c] > f_edge[c+1]) ? f_edge[c] - f_edge[c+1] : '0;
                mlo_reg[c] <= bpwr_reg[HALF_PWR-1:0] * band_reg[c];
                mhi_reg[c] <= bpwr_reg[PWR_W-1:HALF_PWR] * band_reg[c];
                out_reg[c] <= full[OUT_W+39:40];
            end
        end
    end

    assign rgb.valid = vld_reg[TOT_LAT];
    assign rgb.red_intensity = out_reg[COL_RED];
    assign rgb.green_intensity = out_reg[COL_GREEN];
    assign rgb.blue_intensity = out_reg[COL_BLUE];

`ifndef SYNTHESIS
    a_lane_align: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> vld_reg[LANE_LAT] == $past(vld_reg[LANE_LAT-1]))
        else $error("Valid bit did not advance with the pipeline.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("Pipeline moved during a stall.");

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LANE_LAT+1] |-> (band_reg[COL_RED] <= ONE_Q24) &&
            (band_reg[COL_GREEN] <= ONE_Q24) && (band_reg[COL_BLUE] <= ONE_Q24))
        else $error("Band fraction exceeds one.");
`endif

endmodule

`default_nettype wire
